@@ hdl/vca_pkg.sv @@
`timescale 1ns / 1ps
// vca_pkg: widths, register indexes, configuration struct and the exponential
// gain rom of the voltage controlled amplifier core. No dependencies.
package vca_pkg;

    // sample format
    localparam int SAMPLE_BITS    = 16;
    localparam int FRAC_BITS      = SAMPLE_BITS - 3;
    localparam int IN_TDATA_W     = ((4 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;

    // register file
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int GAIN_REG_W     = 15;
    localparam int SCALE_REG_W    = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_GAIN    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CV_B_SCALE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SIG_A_SCALE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SIG_B_SCALE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LEVEL = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_EXP_MODE     = 3'd5;

    // Q2.14 unity
    localparam int Q14_ONE        = 16384;

    typedef struct packed {
        logic [GAIN_REG_W-1:0]  base_gain;
        logic [GAIN_REG_W-1:0]  cv_b_scale;
        logic [SCALE_REG_W-1:0] sig_a_scale;
        logic [SCALE_REG_W-1:0] sig_b_scale;
        logic [SCALE_REG_W-1:0] output_level;
        logic                   exp_mode;
    } cfg_t;

    // datapath widths
    localparam int CV_PROD_W      = SAMPLE_BITS + GAIN_REG_W + 1;
    localparam int MIX_PROD_W     = SAMPLE_BITS + SCALE_REG_W + 1;
    localparam int V_SUM_W        = SAMPLE_BITS + 18;
    localparam int V_W            = V_SUM_W - FRAC_BITS;
    localparam int MIX_SUM_W      = MIX_PROD_W + 1;
    localparam int MIX_W          = MIX_SUM_W - 14;

    // exponential rom
    localparam int EXP_TABLE_BITS = 8;
    localparam int ROM_N          = 1 << EXP_TABLE_BITS;
    localparam int IDX_W          = EXP_TABLE_BITS + 1;
    localparam int ROM_W          = 28;
    localparam int POS_FRAC_W     = 15;
    localparam int VCLAMP_W       = 16;
    localparam int INTERP_W       = ROM_W + POS_FRAC_W;

    localparam int G_W            = (V_W > ROM_W + 1) ? V_W : ROM_W + 1;
    localparam int GL_W           = G_W + 2;
    localparam int Y_W            = GL_W + MIX_W;

    localparam longint          EXPC_Q32 = 64'sd57068181052;
    localparam longint unsigned LN2_Q30  = 64'd744261118;

    typedef logic [ROM_W-1:0] exp_rom_t [0:ROM_N];

    // floored quotient by shift and subtract, used while building the rom
    function automatic longint unsigned floor_quot(input longint unsigned num,
                                                   input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        int              b;
        q = '0;
        r = '0;
        for (b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // 2^y in Q14 for y in Q32, 12-term series for the fractional power
    function automatic longint unsigned exp_rom_entry(input int k);
        longint          y;
        longint          ip;
        longint          fr;
        longint unsigned t;
        longint unsigned sum;
        longint unsigned term;
        int              sh;
        int              n;
        y    = (EXPC_Q32 * longint'(2 * k - ROM_N)) >>> EXP_TABLE_BITS;
        ip   = y >>> 32;
        fr   = y - ip * 64'sd4294967296;
        t    = ($unsigned(fr >>> 2) * LN2_Q30) >> 30;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (n = 1; n <= 12; n++) begin
            term = floor_quot((term * t) >> 30, 64'(n));
            sum  = sum + term;
        end
        sh = 16 - int'(ip);
        return (sum + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic exp_rom_t build_exp_rom();
        exp_rom_t r;
        int       k;
        for (k = 0; k <= ROM_N; k++) begin
            r[k] = ROM_W'(exp_rom_entry(k));
        end
        return r;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

@@ hdl/vca_cfg.sv @@
`timescale 1ns / 1ps
// vca_cfg: configuration register file written through the index/data channel.
// Depends on vca_pkg for register indexes and the cfg_t struct.
module vca_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [vca_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vca_pkg::CFG_DATA_W-1:0]   cfg_data,
    output vca_pkg::cfg_t                    cfg
);

    vca_pkg::cfg_t cfg_reg;
    vca_pkg::cfg_t cfg_next;

    // decode one register transfer, unknown indexes leave everything alone
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                vca_pkg::REG_BASE_GAIN:
                    cfg_next.base_gain = cfg_data[vca_pkg::GAIN_REG_W-1:0];
                vca_pkg::REG_CV_B_SCALE:
                    cfg_next.cv_b_scale = cfg_data[vca_pkg::GAIN_REG_W-1:0];
                vca_pkg::REG_SIG_A_SCALE:
                    cfg_next.sig_a_scale = cfg_data[vca_pkg::SCALE_REG_W-1:0];
                vca_pkg::REG_SIG_B_SCALE:
                    cfg_next.sig_b_scale = cfg_data[vca_pkg::SCALE_REG_W-1:0];
                vca_pkg::REG_OUTPUT_LEVEL:
                    cfg_next.output_level = cfg_data[vca_pkg::SCALE_REG_W-1:0];
                vca_pkg::REG_EXP_MODE:
                    cfg_next.exp_mode = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_gain    <= '0;
            cfg_reg.cv_b_scale   <= '0;
            cfg_reg.sig_a_scale  <= vca_pkg::SCALE_REG_W'(vca_pkg::Q14_ONE);
            cfg_reg.sig_b_scale  <= vca_pkg::SCALE_REG_W'(vca_pkg::Q14_ONE);
            cfg_reg.output_level <= vca_pkg::SCALE_REG_W'(vca_pkg::Q14_ONE);
            cfg_reg.exp_mode     <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/vca_front.sv @@
`timescale 1ns / 1ps
// vca_front: first two pipeline stages, scale products then the control value
// and the signal mix. Depends on vca_pkg.
module vca_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  adv,
    input  vca_pkg::cfg_t                         cfg,
    input  logic                                  in_valid,
    input  logic signed [vca_pkg::SAMPLE_BITS-1:0] gain_cv_a,
    input  logic signed [vca_pkg::SAMPLE_BITS-1:0] gain_cv_b,
    input  logic signed [vca_pkg::SAMPLE_BITS-1:0] signal_a,
    input  logic signed [vca_pkg::SAMPLE_BITS-1:0] signal_b,
    output logic                                  out_valid,
    output logic signed [vca_pkg::V_W-1:0]        out_v,
    output logic signed [vca_pkg::MIX_W-1:0]      out_mix
);

    localparam int SB = vca_pkg::SAMPLE_BITS;
    localparam int VS = vca_pkg::V_SUM_W;
    localparam int FB = vca_pkg::FRAC_BITS;

    logic                                   s1_valid_reg;
    logic signed [SB-1:0]                   s1_cva_reg;
    logic signed [vca_pkg::CV_PROD_W-1:0]   s1_cvb_prod_reg;
    logic signed [vca_pkg::MIX_PROD_W-1:0]  s1_sa_prod_reg;
    logic signed [vca_pkg::MIX_PROD_W-1:0]  s1_sb_prod_reg;

    logic signed [vca_pkg::CV_PROD_W-1:0]   cvb_prod_next;
    logic signed [vca_pkg::MIX_PROD_W-1:0]  sa_prod_next;
    logic signed [vca_pkg::MIX_PROD_W-1:0]  sb_prod_next;

    logic                                   s2_valid_reg;
    logic signed [vca_pkg::V_W-1:0]         s2_v_reg;
    logic signed [vca_pkg::MIX_W-1:0]       s2_mix_reg;

    logic signed [VS-1:0]                   base_term;
    logic signed [VS-1:0]                   cva_term;
    logic signed [VS-1:0]                   cvb_term;
    logic signed [VS-1:0]                   v_sum;
    logic signed [vca_pkg::MIX_SUM_W-1:0]   mix_sum;

    // stage 1: the three scale multiplications
    always_comb begin
        cvb_prod_next = gain_cv_b * $signed({1'b0, cfg.cv_b_scale});
        sa_prod_next  = signal_a * $signed({1'b0, cfg.sig_a_scale});
        sb_prod_next  = signal_b * $signed({1'b0, cfg.sig_b_scale});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_cva_reg      <= gain_cv_a;
            s1_cvb_prod_reg <= cvb_prod_next;
            s1_sa_prod_reg  <= sa_prod_next;
            s1_sb_prod_reg  <= sb_prod_next;
        end
    end

    // stage 2: control value in Q14 and the mix, both floored
    always_comb begin
        base_term = $signed(VS'({cfg.base_gain, {FB{1'b0}}}));
        cva_term  = {{(VS - SB - 14){s1_cva_reg[SB-1]}}, s1_cva_reg, 14'b0};
        cvb_term  = VS'(s1_cvb_prod_reg);
        v_sum     = base_term + cva_term + cvb_term;
        mix_sum   = vca_pkg::MIX_SUM_W'(s1_sa_prod_reg) + vca_pkg::MIX_SUM_W'(s1_sb_prod_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_v_reg   <= v_sum[FB +: vca_pkg::V_W];
            s2_mix_reg <= mix_sum[14 +: vca_pkg::MIX_W];
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_v     = s2_v_reg;
    assign out_mix   = s2_mix_reg;

endmodule

@@ hdl/vca_gain.sv @@
`timescale 1ns / 1ps
// vca_gain: gain law stages, rom lookup, interpolation product and gain select.
// Depends on vca_pkg for the exponential rom and widths.
module vca_gain (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  vca_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    input  logic signed [vca_pkg::V_W-1:0]    in_v,
    input  logic signed [vca_pkg::MIX_W-1:0]  in_mix,
    output logic                              out_valid,
    output logic signed [vca_pkg::G_W-1:0]    out_gain,
    output logic signed [vca_pkg::MIX_W-1:0]  out_mix
);

    localparam int VW  = vca_pkg::V_W;
    localparam int RW  = vca_pkg::ROM_W;
    localparam int ETB = vca_pkg::EXP_TABLE_BITS;
    localparam int PFW = vca_pkg::POS_FRAC_W;

    localparam logic [1:0] GAIN_ZERO = 2'd0;
    localparam logic [1:0] GAIN_LIN  = 2'd1;
    localparam logic [1:0] GAIN_EXP  = 2'd2;

    localparam logic [VW-2:0]              V_TWO   = (VW - 1)'(2 * vca_pkg::Q14_ONE);
    localparam logic [vca_pkg::IDX_W-1:0]  IDX_TOP = vca_pkg::IDX_W'(vca_pkg::ROM_N);

    // stage 3 lookup
    logic                          v_pos;
    logic [vca_pkg::VCLAMP_W-1:0]  v_clamp;
    logic [vca_pkg::IDX_W-1:0]     idx0;
    logic [vca_pkg::IDX_W-1:0]     idx1;
    logic [PFW-1:0]                pos_frac;
    logic [1:0]                    sel_next;

    logic                          s3_valid_reg;
    logic [1:0]                    s3_sel_reg;
    logic signed [VW-1:0]          s3_v_reg;
    logic signed [vca_pkg::MIX_W-1:0] s3_mix_reg;
    logic [RW-1:0]                 s3_r0_reg;
    logic [RW-1:0]                 s3_r1_reg;
    logic [PFW-1:0]                s3_frac_reg;

    // stage 4 interpolation product
    logic [RW-1:0]                 rom_diff;
    logic [vca_pkg::INTERP_W-1:0]  interp_next;

    logic                          s4_valid_reg;
    logic [1:0]                    s4_sel_reg;
    logic signed [VW-1:0]          s4_v_reg;
    logic signed [vca_pkg::MIX_W-1:0] s4_mix_reg;
    logic [RW-1:0]                 s4_r0_reg;
    logic [vca_pkg::INTERP_W-1:0]  s4_interp_reg;

    // stage 5 gain select
    logic [RW-1:0]                 exp_gain;
    logic signed [vca_pkg::G_W-1:0] gain_next;

    logic                          s5_valid_reg;
    logic signed [vca_pkg::G_W-1:0] s5_gain_reg;
    logic signed [vca_pkg::MIX_W-1:0] s5_mix_reg;

    // clamp to 2.0 and split the rom position into index and fraction
    always_comb begin
        v_pos    = !in_v[VW-1] && (in_v != '0);
        v_clamp  = (in_v[VW-2:0] > V_TWO) ? vca_pkg::VCLAMP_W'(2 * vca_pkg::Q14_ONE)
                                          : in_v[vca_pkg::VCLAMP_W-1:0];
        idx0     = v_clamp[vca_pkg::VCLAMP_W-1 -: vca_pkg::IDX_W];
        idx1     = (idx0 == IDX_TOP) ? idx0 : idx0 + 1'b1;
        pos_frac = {v_clamp[PFW-1-ETB:0], {ETB{1'b0}}};
        if (!cfg.exp_mode) begin
            sel_next = GAIN_LIN;
        end else if (v_pos) begin
            sel_next = GAIN_EXP;
        end else begin
            sel_next = GAIN_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= in_valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_sel_reg  <= sel_next;
            s3_v_reg    <= in_v;
            s3_mix_reg  <= in_mix;
            s3_r0_reg   <= vca_pkg::EXP_ROM[idx0];
            s3_r1_reg   <= vca_pkg::EXP_ROM[idx1];
            s3_frac_reg <= pos_frac;
        end
    end

    // rom is rising, so the neighbor difference is never negative
    always_comb begin
        rom_diff    = s3_r1_reg - s3_r0_reg;
        interp_next = vca_pkg::INTERP_W'(rom_diff) * vca_pkg::INTERP_W'(s3_frac_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_sel_reg    <= s3_sel_reg;
            s4_v_reg      <= s3_v_reg;
            s4_mix_reg    <= s3_mix_reg;
            s4_r0_reg     <= s3_r0_reg;
            s4_interp_reg <= interp_next;
        end
    end

    // pick zero, the control value itself or the interpolated exponential
    always_comb begin
        exp_gain = s4_r0_reg + s4_interp_reg[PFW +: RW];
        unique case (s4_sel_reg)
            GAIN_LIN:  gain_next = vca_pkg::G_W'(s4_v_reg);
            GAIN_EXP:  gain_next = $signed(vca_pkg::G_W'(exp_gain));
            default:   gain_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_gain_reg <= gain_next;
            s5_mix_reg  <= s4_mix_reg;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_gain  = s5_gain_reg;
    assign out_mix   = s5_mix_reg;

endmodule

@@ hdl/vca_out.sv @@
`timescale 1ns / 1ps
// vca_out: level scaling, final product with rounding and the saturating output
// register that drives the result channel. Depends on vca_pkg.
module vca_out (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   adv,
    input  vca_pkg::cfg_t                          cfg,
    input  logic                                   in_valid,
    input  logic signed [vca_pkg::G_W-1:0]         in_gain,
    input  logic signed [vca_pkg::MIX_W-1:0]       in_mix,
    output logic                                   out_valid,
    output logic signed [vca_pkg::SAMPLE_BITS-1:0] out_sample,
    output logic                                   out_clipped
);

    localparam int SB   = vca_pkg::SAMPLE_BITS;
    localparam int YW   = vca_pkg::Y_W;
    localparam int YS_W = YW - 14;
    localparam int LP_W = vca_pkg::G_W + vca_pkg::SCALE_REG_W + 1;

    localparam logic signed [YW-1:0] ROUND_HALF = YW'(1 << 13);
    localparam logic signed [SB-1:0] SAT_HI     = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0] SAT_LO     = {1'b1, {(SB - 1){1'b0}}};

    logic signed [LP_W-1:0]              level_prod;
    logic                                s6_valid_reg;
    logic signed [vca_pkg::GL_W-1:0]     s6_gl_reg;
    logic signed [vca_pkg::MIX_W-1:0]    s6_mix_reg;

    logic signed [YW-1:0]                y_next;
    logic                                s7_valid_reg;
    logic signed [YW-1:0]                s7_y_reg;

    logic signed [YS_W-1:0]              y_shift;
    logic                                ovf_pos;
    logic                                ovf_neg;
    logic signed [SB-1:0]                sample_next;
    logic                                clip_next;

    logic                                out_valid_reg;
    logic signed [SB-1:0]                sample_reg;
    logic                                clip_reg;

    // stage 6: apply the output level, floored Q14
    assign level_prod = in_gain * $signed({1'b0, cfg.output_level});

    // stage 7: gain times mix plus half an lsb
    assign y_next = s6_gl_reg * s6_mix_reg + ROUND_HALF;

    // output stage: drop fraction bits and clamp to the sample range
    always_comb begin
        y_shift     = s7_y_reg[14 +: YS_W];
        ovf_pos     = !y_shift[YS_W-1] && (|y_shift[YS_W-2:SB-1]);
        ovf_neg     = y_shift[YS_W-1] && !(&y_shift[YS_W-2:SB-1]);
        clip_next   = ovf_pos || ovf_neg;
        if (ovf_pos) begin
            sample_next = SAT_HI;
        end else if (ovf_neg) begin
            sample_next = SAT_LO;
        end else begin
            sample_next = y_shift[SB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s6_valid_reg  <= in_valid;
            s7_valid_reg  <= s6_valid_reg;
            out_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_gl_reg  <= level_prod[14 +: vca_pkg::GL_W];
            s6_mix_reg <= in_mix;
            s7_y_reg   <= y_next;
            sample_reg <= sample_next;
            clip_reg   <= clip_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_sample  = sample_reg;
    assign out_clipped = clip_reg;

endmodule

@@ hdl/voltage_controlled_amplifier_core.sv @@
`timescale 1ns / 1ps
// voltage_controlled_amplifier_core: top level joining the register file and
// the three pipeline parts. Depends on vca_pkg, vca_cfg, vca_front, vca_gain, vca_out.
//
// Usage:
//   s_ channel: one transfer per sample carries gain_cv_a, gain_cv_b, signal_a
//   and signal_b (signed Q2.13). m_ channel: one transfer per sample returns
//   amplified_sample on m_tdata and the clipped flag on m_tuser.
//   cfg channel: index/data register writes, always ready; write only while
//   no sample is in flight. Indexes past the register list are ignored.
//   From an s_ transfer to m_tvalid of its result a sample passes through
//   eight register stages (scale products, control and mix sums, rom lookup,
//   interpolation product, gain select, level product, final product, output
//   saturation register).
//   Throughput: one sample per cycle unless stalled; up to eight in flight.
//   Stalls: while m_tvalid is high and m_tready low the whole pipeline holds
//   and s_tready drops, so nothing is dropped or repeated; a new sample is
//   still taken in the cycle the waiting result leaves.
//   Reset: aresetn low at a clock edge empties the pipeline and loads the
//   register defaults (unity signal scales and level, linear law).
module voltage_controlled_amplifier_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // register write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vca_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [vca_pkg::CFG_DATA_W-1:0]       cfg_data,
    // sample input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // low to high: gain_cv_a, gain_cv_b, signal_a, signal_b
    input  logic [vca_pkg::IN_TDATA_W-1:0]       s_tdata,
    // result output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // amplified_sample
    output logic [vca_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // clipped
    output logic [0:0]                           m_tuser
);

    localparam int SB = vca_pkg::SAMPLE_BITS;

    vca_pkg::cfg_t                     cfg;
    logic                              adv;
    logic                              front_valid;
    logic signed [vca_pkg::V_W-1:0]    front_v;
    logic signed [vca_pkg::MIX_W-1:0]  front_mix;
    logic                              gain_valid;
    logic signed [vca_pkg::G_W-1:0]    gain_val;
    logic signed [vca_pkg::MIX_W-1:0]  gain_mix;
    logic signed [SB-1:0]              out_sample;
    logic                              out_clipped;

    // pipeline moves whenever the output register is empty or being taken
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    vca_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vca_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .gain_cv_a ($signed(s_tdata[0 * SB +: SB])),
        .gain_cv_b ($signed(s_tdata[1 * SB +: SB])),
        .signal_a  ($signed(s_tdata[2 * SB +: SB])),
        .signal_b  ($signed(s_tdata[3 * SB +: SB])),
        .out_valid (front_valid),
        .out_v     (front_v),
        .out_mix   (front_mix)
    );

    vca_gain u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (front_valid),
        .in_v      (front_v),
        .in_mix    (front_mix),
        .out_valid (gain_valid),
        .out_gain  (gain_val),
        .out_mix   (gain_mix)
    );

    vca_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .cfg         (cfg),
        .in_valid    (gain_valid),
        .in_gain     (gain_val),
        .in_mix      (gain_mix),
        .out_valid   (m_tvalid),
        .out_sample  (out_sample),
        .out_clipped (out_clipped)
    );

    assign m_tdata    = vca_pkg::OUT_TDATA_W'($unsigned(out_sample));
    assign m_tuser[0] = out_clipped;

endmodule
